### rtl/greedy_box_suppression_assert.svh
// Assertion macros used by the greedy box suppression RTL.
// Every property is sampled on the rising edge of clk and is disabled while rst is high.
`ifndef GREEDY_BOX_SUPPRESSION_ASSERT_SVH
`define GREEDY_BOX_SUPPRESSION_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GBS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GBS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/gbs_pkg.sv
package gbs_pkg;

  // Size of the kept-box store.
  localparam int MAX_KEPT   = 64;
  localparam int KEPT_IDX_W = $clog2(MAX_KEPT);
  localparam int KEPT_CNT_W = $clog2(MAX_KEPT + 1);

  localparam logic [15:0] IOU_THRESHOLD_RESET = 16'd29491;

  // One input transaction: a box and the end-of-set flag.
  typedef struct packed {
    logic signed [15:0] box_left;
    logic signed [15:0] box_top;
    logic [14:0]        box_width;
    logic [14:0]        box_height;
    logic               last_box;
  } box_in_t;

  // One result transaction.
  typedef struct packed {
    logic        keep;
    logic [15:0] box_index;
    logic        store_overflow;
    logic        set_done;
  } box_result_t;

  // One entry of the kept-box memory.
  typedef struct packed {
    logic [29:0]        area;
    logic [14:0]        height;
    logic [14:0]        width;
    logic signed [15:0] top;
    logic signed [15:0] left;
  } kept_entry_t;

  // Length of the overlap of [a0, a1) and [b0, b1), zero when they do not overlap.
  function automatic logic [16:0] overlap_len(input logic signed [16:0] a0,
                                              input logic signed [16:0] a1,
                                              input logic signed [16:0] b0,
                                              input logic signed [16:0] b1);
    logic signed [16:0] lo;
    logic signed [16:0] hi;
    logic signed [17:0] diff;
    lo   = (a0 > b0) ? a0 : b0;
    hi   = (a1 < b1) ? a1 : b1;
    diff = {hi[16], hi} - {lo[16], lo};
    overlap_len = (hi > lo) ? diff[16:0] : 17'd0;
  endfunction

endpackage

### rtl/greedy_box_suppression.sv
// Greedy IoU non-maximum suppression over score-sorted boxes, one transaction at a time.
// An accepted box passes through setup, a scan with one memory read per kept box, a drain
// of the read and four compare stages, and finish; the result strobe follows the finish
// state. The receiver cannot stall; busy falls with the strobe, and the next start is
// taken only once busy is low. Synchronous reset clears the kept count, set position and
// pipeline and loads threshold 29491, not the memory.
module greedy_box_suppression
  import gbs_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  box_in_t       box,
  input  logic          threshold_we,
  input  logic [15:0]   threshold_data,
  output logic          result_strobe,
  output box_result_t   result
);

  `include "greedy_box_suppression_assert.svh"

  // Sequencer states.
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SETUP  = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_DRAIN  = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  logic [2:0]            state;
  logic [2:0]            state_next;

  logic [15:0]           iou_threshold;
  logic [KEPT_CNT_W-1:0] kept_count;
  logic [15:0]           set_position;

  // The box under test. Its right and bottom edges and its area are formed in the setup
  // cycle so that the scan pipeline only sees registered values.
  box_in_t               cur;
  logic signed [16:0]    cur_right;
  logic signed [16:0]    cur_bottom;
  logic [29:0]           cur_area;
  logic                  keep_flag;

  // Kept-box memory: one write port used when a box is stored, one registered read port
  // that the scan walks from entry 0 to kept_count - 1.
  kept_entry_t           kept_mem [MAX_KEPT];
  kept_entry_t           rd_data;
  logic [KEPT_CNT_W-1:0] rd_idx;
  logic                  issue;
  logic                  mem_we;
  kept_entry_t           wr_entry;

  // Comparison pipeline. Each stage carries a valid bit.
  logic                  rd_v;
  logic                  s1_v;
  logic                  s2_v;
  logic                  s3_v;
  logic                  s4_v;
  logic [16:0]           s1_ow;
  logic [16:0]           s1_oh;
  logic [29:0]           s1_karea;
  logic [33:0]           s2_inter;
  logic [29:0]           s2_karea;
  logic [33:0]           s3_inter;
  logic [30:0]           s3_uni;
  logic [33:0]           s4_inter;
  logic [46:0]           s4_prod;
  logic                  suppress_hit;
  logic                  pipe_busy;

  logic signed [16:0]    k_left;
  logic signed [16:0]    k_top;
  logic signed [16:0]    k_right;
  logic signed [16:0]    k_bottom;
  logic signed [16:0]    c_left;
  logic signed [16:0]    c_top;

  logic                  store_room;

  assign busy       = (state != ST_IDLE);
  assign issue      = (state == ST_SCAN) && (rd_idx < kept_count);
  assign pipe_busy  = rd_v | s1_v | s2_v | s3_v | s4_v;
  assign store_room = (kept_count < KEPT_CNT_W'(MAX_KEPT));
  assign mem_we     = (state == ST_FINISH) && keep_flag && store_room;

  // Sign-extend the stored box and the current box to 17 bits and form the kept box edges.
  assign k_left   = {rd_data.left[15], rd_data.left};
  assign k_top    = {rd_data.top[15], rd_data.top};
  assign k_right  = k_left + $signed({2'b00, rd_data.width});
  assign k_bottom = k_top + $signed({2'b00, rd_data.height});
  assign c_left   = {cur.box_left[15], cur.box_left};
  assign c_top    = {cur.box_top[15], cur.box_top};

  // The division-free IoU test: intersection * 2^16 against threshold * union.
  assign suppress_hit = s4_v && ({s4_inter, 16'd0} > {3'd0, s4_prod});

  assign wr_entry = '{area:   cur_area,
                      height: cur.box_height,
                      width:  cur.box_width,
                      top:    cur.box_top,
                      left:   cur.box_left};

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_SETUP;
        end
      end
      ST_SETUP: begin
        state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (!issue) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!pipe_busy) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Memory ports. The write of a kept box lands in the finish cycle, well before the next
  // transaction can issue its first read, so no forwarding path is needed.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      kept_mem[kept_count[KEPT_IDX_W-1:0]] <= wr_entry;
    end
    rd_data <= kept_mem[rd_idx[KEPT_IDX_W-1:0]];
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      iou_threshold <= IOU_THRESHOLD_RESET;
      kept_count    <= '0;
      set_position  <= '0;
      rd_idx        <= '0;
      keep_flag     <= 1'b0;
      rd_v          <= 1'b0;
      s1_v          <= 1'b0;
      s2_v          <= 1'b0;
      s3_v          <= 1'b0;
      s4_v          <= 1'b0;
      result_strobe <= 1'b0;
    end else begin
      state <= state_next;
      if (threshold_we) begin
        iou_threshold <= threshold_data;
      end

      rd_v <= issue;
      s1_v <= rd_v;
      s2_v <= s1_v;
      s3_v <= s2_v;
      s4_v <= s3_v;

      if (state == ST_SETUP) begin
        rd_idx    <= '0;
        keep_flag <= 1'b1;
      end else begin
        if (issue) begin
          rd_idx <= rd_idx + 1'b1;
        end
        if (suppress_hit) begin
          keep_flag <= 1'b0;
        end
      end

      result_strobe <= (state == ST_FINISH);

      // The finish cycle updates the set bookkeeping. The end of a set overrides both the kept
      // count step and the index step; the memory write of a kept box still lands.
      if (state == ST_FINISH) begin
        if (cur.last_box) begin
          kept_count   <= '0;
          set_position <= '0;
        end else begin
          if (mem_we) begin
            kept_count <= kept_count + 1'b1;
          end
          if (set_position != 16'hFFFF) begin
            set_position <= set_position + 1'b1;
          end
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      cur <= box;
    end
    if (state == ST_SETUP) begin
      cur_right  <= c_left + $signed({2'b00, cur.box_width});
      cur_bottom <= c_top + $signed({2'b00, cur.box_height});
      cur_area   <= cur.box_width * cur.box_height;
    end

    // Stage 1: overlap extents against the kept box just read.
    s1_ow    <= overlap_len(c_left, cur_right, k_left, k_right);
    s1_oh    <= overlap_len(c_top, cur_bottom, k_top, k_bottom);
    s1_karea <= rd_data.area;
    // Stage 2: intersection area.
    s2_inter <= s1_ow * s1_oh;
    s2_karea <= s1_karea;
    // Stage 3: union area; it never goes below the intersection.
    s3_uni   <= 31'(cur_area) + 31'(s2_karea) - s2_inter[30:0];
    s3_inter <= s2_inter;
    // Stage 4: threshold times union.
    s4_prod  <= iou_threshold * s3_uni;
    s4_inter <= s3_inter;

    if (state == ST_FINISH) begin
      result.keep           <= keep_flag;
      result.box_index      <= set_position;
      result.store_overflow <= keep_flag && !store_room;
      result.set_done       <= cur.last_box;
    end
  end

  // An accepted transaction makes the block busy in the next cycle.
  `GBS_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "busy did not rise after start")
  // The store never holds more boxes than it has entries.
  `GBS_ASSERT_SAME(a_count_bound, 1'b1, kept_count <= KEPT_CNT_W'(MAX_KEPT),
                   "kept count exceeds store depth")
  // The scan reads only entries that hold a kept box of the current set.
  `GBS_ASSERT_SAME(a_read_in_range, issue, rd_idx < kept_count, "scan read past kept count")
  // An overflow is only reported for a kept box, and only when the store was full.
  `GBS_ASSERT_SAME(a_ovf_keep, result_strobe && result.store_overflow,
                   result.keep && (kept_count == KEPT_CNT_W'(MAX_KEPT) || result.set_done),
                   "overflow on a suppressed box or with room in the store")
  // The result strobe follows the finish cycle only.
  `GBS_ASSERT_NEXT(a_strobe_finish, state == ST_FINISH, result_strobe,
                   "no result strobe after finish")

endmodule
